// File: hdl/api_pkg.sv
// Shared constants and arctangent table for the arc pose integrator.
`default_nettype none

package api_pkg;

    localparam int POS_BITS_DEF     = 32;
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_ITERS_DEF = 16;

    // Q4.30 signed word used for sin, cos and scale factors
    localparam int QW  = 34;
    // unsigned turn magnitude in Q30 radians
    localparam int TW  = 32;
    // divider dividend width: magnitude shifted up by 30
    localparam int DVW = QW + 30;

    localparam logic [TW-1:0]        PI_Q30   = 32'd3373259426;
    localparam logic signed [QW-1:0] CORDIC_K = 34'sd652032874;
    localparam logic signed [QW-1:0] ONE_Q30  = 34'sd1073741824;

    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: hdl/api_cordic.sv
// Iterative rotation-mode CORDIC giving cos and sin of a binary angle in Q4.30.
`default_nettype none

module api_cordic import api_pkg::*; #(
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
    parameter int CORDIC_ITERS = CORDIC_ITERS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic signed [ANGLE_BITS-1:0] i_angle,
    output logic signed [QW-1:0]              o_cos,
    output logic signed [QW-1:0]              o_sin,
    output logic                              o_done
);

    localparam int IW = $clog2(CORDIC_ITERS);
    localparam int AW = ANGLE_BITS + 1;
    localparam int PW = ANGLE_BITS + TW;
    localparam logic signed [AW-1:0] HALF = AW'(1) <<< (ANGLE_BITS - 1);
    localparam logic signed [AW-1:0] QTR  = AW'(1) <<< (ANGLE_BITS - 2);

    logic                  r_busy;
    logic                  r_done;
    logic [IW-1:0]         r_i;
    logic                  r_flip;
    logic signed [QW-1:0]  r_x;
    logic signed [QW-1:0]  r_y;
    logic signed [QW-1:0]  r_z;

    logic signed [AW-1:0]  a_ext;
    logic signed [AW-1:0]  a_fold;
    logic                  fold;
    logic [ANGLE_BITS-1:0] a_mag;
    logic [PW-1:0]         z_prod;
    logic signed [QW-1:0]  z_mag;
    logic signed [QW-1:0]  z_init;
    logic signed [QW-1:0]  xs;
    logic signed [QW-1:0]  ys;
    logic signed [QW-1:0]  at;

    always_comb begin
        a_ext = {i_angle[ANGLE_BITS-1], i_angle};
        fold  = 1'b0;
        a_fold = a_ext;
        if (a_ext > QTR) begin
            a_fold = a_ext - HALF;
            fold   = 1'b1;
        end else if (a_ext < -QTR) begin
            a_fold = a_ext + HALF;
            fold   = 1'b1;
        end
        a_mag  = a_fold[AW-1] ? ANGLE_BITS'(-a_fold) : ANGLE_BITS'(a_fold);
        z_prod = PW'(a_mag) * PW'(PI_Q30);
        z_mag  = $signed(QW'(z_prod[PW-2:ANGLE_BITS-1]));
        z_init = a_fold[AW-1] ? -z_mag : z_mag;
        xs     = r_y >>> r_i;
        ys     = r_x >>> r_i;
        at     = $signed(QW'(atan_q30(5'(r_i))));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_i == IW'(CORDIC_ITERS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_K;
            r_y    <= '0;
            r_z    <= z_init;
            r_flip <= fold;
            r_i    <= '0;
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - xs;
                r_y <= r_y + ys;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + xs;
                r_y <= r_y - ys;
                r_z <= r_z + at;
            end
            r_i <= r_i + IW'(1);
        end
    end

    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;
    assign o_done = r_done;

endmodule

`default_nettype wire

// File: hdl/api_div.sv
// Restoring divider, one quotient bit per cycle: trunc(num * 2^30 / den).
`default_nettype none

module api_div import api_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [QW-1:0] i_num,
    input  wire logic [TW-1:0]        i_den,
    output logic signed [QW-1:0]      o_quo,
    output logic                      o_done
);

    localparam int CW = $clog2(DVW);

    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    logic            r_neg;
    logic [TW-1:0]   r_den;
    logic [TW:0]     r_rem;
    logic [DVW-1:0]  r_dvd;

    logic [QW-1:0]   num_mag;
    logic [TW:0]     rem_sh;
    logic            ge;

    always_comb begin
        num_mag = i_num[QW-1] ? QW'(-i_num) : QW'(i_num);
        rem_sh  = {r_rem[TW-1:0], r_dvd[DVW-1]};
        ge      = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(DVW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[QW-1];
            r_den <= i_den;
            r_rem <= '0;
            r_dvd <= {num_mag, 30'b0};
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sh - {1'b0, r_den} : rem_sh;
            r_dvd <= {r_dvd[DVW-2:0], ge};
            r_cnt <= r_cnt + CW'(1);
        end
    end

    assign o_quo  = r_neg ? -$signed(r_dvd[QW-1:0]) : $signed(r_dvd[QW-1:0]);
    assign o_done = r_done;

endmodule

`default_nettype wire

// File: hdl/api_mul.sv
// Two-pass Q30 multiplier: trunc(p * q / 2^30), sign and magnitude.
`default_nettype none

module api_mul import api_pkg::*; #(
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic signed [POS_BITS+2:0]   i_p,
    input  wire logic signed [QW-1:0]         i_q,
    output logic signed [POS_BITS+2:0]        o_r,
    output logic                              o_done
);

    localparam int XW = POS_BITS + 3;
    localparam int AW = XW + QW;

    logic           r_busy;
    logic           r_ph;
    logic           r_done;
    logic           r_neg;
    logic [XW-1:0]  r_pm;
    logic [QW-1:0]  r_qm;
    logic [AW-1:0]  r_acc;

    logic [XW-1:0]  p_mag;
    logic [QW-1:0]  q_mag;
    logic [XW-1:0]  res;

    always_comb begin
        p_mag = i_p[XW-1] ? XW'(-i_p) : XW'(i_p);
        q_mag = i_q[QW-1] ? QW'(-i_q) : QW'(i_q);
        res   = r_acc[XW+29:30];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_ph) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_pm  <= p_mag;
            r_qm  <= q_mag;
            r_neg <= i_p[XW-1] ^ i_q[QW-1];
            r_ph  <= 1'b0;
        end else if (r_busy) begin
            if (!r_ph) begin
                r_acc <= AW'(r_pm[15:0]) * AW'(r_qm);
            end else begin
                r_acc <= r_acc + ((AW'(r_pm[XW-1:16]) * AW'(r_qm)) << 16);
            end
            r_ph <= 1'b1;
        end
    end

    assign o_r    = r_neg ? -$signed(res) : $signed(res);
    assign o_done = r_done;

endmodule

`default_nettype wire

// File: hdl/arc_pose_integrator.sv
// Top level: planar arc odometry pose integrator with shared CORDIC, divider and multiplier.
//
// Each item (arc distance, turn angle) advances the stored pose (x, y, heading) and yields
// one result item with the new pose. Work runs under a sequencer that reuses one CORDIC,
// one restoring divider and one two-pass multiplier, so one item is in flight at a time and
// the input stalls until the result is taken. A turning step runs two CORDIC passes, two
// 64-step divisions and six two-pass multiplications; a step with zero turn skips the first
// CORDIC pass, the divisions and the two multiplications that scale the distance, and runs
// one CORDIC pass and four multiplications. A step also waits in the output state while
// the output stalls. Configuration writes set the pose directly and are taken while the
// block is idle.
`default_nettype none

module arc_pose_integrator import api_pkg::*; #(
    parameter int POS_BITS     = POS_BITS_DEF,
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
    parameter int CORDIC_ITERS = CORDIC_ITERS_DEF
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_in_valid,
    output logic                                          o_in_stall,
    input  wire logic signed [POS_BITS-1:0]               i_arc_distance,
    input  wire logic signed [ANGLE_BITS-1:0]             i_turn_angle,
    output logic                                          o_out_valid,
    input  wire logic                                     i_out_stall,
    output logic signed [POS_BITS-1:0]                    o_pose_x,
    output logic signed [POS_BITS-1:0]                    o_pose_y,
    output logic signed [ANGLE_BITS-1:0]                  o_pose_heading,
    input  wire logic                                     i_cfg_valid,
    output logic                                          o_cfg_ready,
    input  wire logic [1:0]                               i_cfg_index,
    input  wire logic [((POS_BITS > ANGLE_BITS) ? POS_BITS : ANGLE_BITS)-1:0] i_cfg_data
);

    localparam int XW = POS_BITS + 3;
    localparam int GW = XW + 1;
    localparam int SW = XW + 2;
    localparam int PW = ANGLE_BITS + TW;
    localparam logic signed [SW-1:0] SMAX = (SW'(1) <<< (POS_BITS - 1)) - SW'(1);
    localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

    localparam logic [1:0] REG_START_X       = 2'd0;
    localparam logic [1:0] REG_START_Y       = 2'd1;
    localparam logic [1:0] REG_START_HEADING = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_TCORD, ST_KS, ST_KM, ST_DX, ST_DY, ST_HCORD,
        ST_GXA, ST_GXB, ST_GYA, ST_GYB, ST_UPD, ST_OUT
    } t_state;

    t_state                        r_state;
    logic                          r_go;
    logic signed [POS_BITS-1:0]    r_cur_x;
    logic signed [POS_BITS-1:0]    r_cur_y;
    logic signed [ANGLE_BITS-1:0]  r_heading;
    logic signed [POS_BITS-1:0]    r_d;
    logic signed [ANGLE_BITS-1:0]  r_a;
    logic [TW-1:0]                 r_t;
    logic signed [QW-1:0]          r_ks;
    logic signed [QW-1:0]          r_km;
    logic signed [XW-1:0]          r_dx;
    logic signed [XW-1:0]          r_dy;
    logic signed [GW-1:0]          r_gx;
    logic signed [GW-1:0]          r_gy;

    logic                          cord_start;
    logic signed [ANGLE_BITS-1:0]  cord_angle;
    logic signed [QW-1:0]          cord_cos;
    logic signed [QW-1:0]          cord_sin;
    logic                          cord_done;
    logic                          div_start;
    logic signed [QW-1:0]          div_num;
    logic signed [QW-1:0]          div_quo;
    logic                          div_done;
    logic                          mul_start;
    logic signed [XW-1:0]          mul_p;
    logic signed [QW-1:0]          mul_q;
    logic signed [XW-1:0]          mul_r;
    logic                          mul_done;
    logic                          unit_done;

    logic [ANGLE_BITS-1:0]         turn_mag;
    logic [PW-1:0]                 turn_prod;
    logic signed [XW-1:0]          d_ext;
    logic signed [GW-1:0]          mul_ext;
    logic signed [SW-1:0]          sum_x;
    logic signed [SW-1:0]          sum_y;
    logic signed [QW-1:0]          cos_m1;

    always_comb begin
        turn_mag  = i_turn_angle[ANGLE_BITS-1] ? ANGLE_BITS'(-i_turn_angle)
                                               : ANGLE_BITS'(i_turn_angle);
        turn_prod = PW'(turn_mag) * PW'(PI_Q30);
        d_ext     = XW'(r_d);
        mul_ext   = GW'(mul_r);
        cos_m1    = cord_cos - ONE_Q30;
        sum_x     = SW'(r_cur_x) + SW'(r_gx);
        sum_y     = SW'(r_cur_y) + SW'(r_gy);

        cord_angle = (r_state == ST_TCORD) ? r_a : r_heading;
        cord_start = !r_go && (r_state == ST_TCORD || r_state == ST_HCORD);
        div_start  = !r_go && (r_state == ST_KS || r_state == ST_KM);
        mul_start  = !r_go && (r_state == ST_DX || r_state == ST_DY ||
                               r_state == ST_GXA || r_state == ST_GXB ||
                               r_state == ST_GYA || r_state == ST_GYB);

        if (r_state == ST_KS) begin
            div_num = r_a[ANGLE_BITS-1] ? -cord_sin : cord_sin;
        end else begin
            div_num = r_a[ANGLE_BITS-1] ? -cos_m1 : cos_m1;
        end

        case (r_state)
            ST_DX: begin
                mul_p = d_ext;
                mul_q = r_ks;
            end
            ST_DY: begin
                mul_p = d_ext;
                mul_q = r_km;
            end
            ST_GXA: begin
                mul_p = r_dx;
                mul_q = cord_cos;
            end
            ST_GXB: begin
                mul_p = r_dy;
                mul_q = cord_sin;
            end
            ST_GYA: begin
                mul_p = r_dx;
                mul_q = cord_sin;
            end
            default: begin
                mul_p = r_dy;
                mul_q = cord_cos;
            end
        endcase

        case (r_state)
            ST_TCORD, ST_HCORD: unit_done = cord_done;
            ST_KS, ST_KM:       unit_done = div_done;
            default:            unit_done = mul_done;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_go      <= 1'b0;
            r_cur_x   <= '0;
            r_cur_y   <= '0;
            r_heading <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_START_X:       r_cur_x   <= i_cfg_data[POS_BITS-1:0];
                    REG_START_Y:       r_cur_y   <= i_cfg_data[POS_BITS-1:0];
                    REG_START_HEADING: r_heading <= i_cfg_data[ANGLE_BITS-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_d <= i_arc_distance;
                        r_a <= i_turn_angle;
                        r_t <= turn_prod[PW-2:ANGLE_BITS-1];
                        if (i_turn_angle == '0) begin
                            r_dx    <= XW'(i_arc_distance);
                            r_dy    <= '0;
                            r_state <= ST_HCORD;
                        end else begin
                            r_state <= ST_TCORD;
                        end
                    end
                end
                ST_UPD: begin
                    r_cur_x   <= (sum_x > SMAX) ? SMAX[POS_BITS-1:0] :
                                 (sum_x < SMIN) ? SMIN[POS_BITS-1:0] : sum_x[POS_BITS-1:0];
                    r_cur_y   <= (sum_y > SMAX) ? SMAX[POS_BITS-1:0] :
                                 (sum_y < SMIN) ? SMIN[POS_BITS-1:0] : sum_y[POS_BITS-1:0];
                    r_heading <= r_heading + r_a;
                    r_state   <= ST_OUT;
                end
                ST_OUT: begin
                    if (!i_out_stall) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    if (!r_go) begin
                        r_go <= 1'b1;
                    end else if (unit_done) begin
                        r_go <= 1'b0;
                        case (r_state)
                            ST_TCORD: r_state <= ST_KS;
                            ST_KS: begin
                                r_ks    <= div_quo;
                                r_state <= ST_KM;
                            end
                            ST_KM: begin
                                r_km    <= div_quo;
                                r_state <= ST_DX;
                            end
                            ST_DX: begin
                                r_dx    <= mul_r;
                                r_state <= ST_DY;
                            end
                            ST_DY: begin
                                r_dy    <= mul_r;
                                r_state <= ST_HCORD;
                            end
                            ST_HCORD: r_state <= ST_GXA;
                            ST_GXA: begin
                                r_gx    <= mul_ext;
                                r_state <= ST_GXB;
                            end
                            ST_GXB: begin
                                r_gx    <= r_gx - mul_ext;
                                r_state <= ST_GYA;
                            end
                            ST_GYA: begin
                                r_gy    <= mul_ext;
                                r_state <= ST_GYB;
                            end
                            default: begin
                                r_gy    <= r_gy + mul_ext;
                                r_state <= ST_UPD;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    api_cordic #(
        .ANGLE_BITS   (ANGLE_BITS),
        .CORDIC_ITERS (CORDIC_ITERS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_angle (cord_angle),
        .o_cos   (cord_cos),
        .o_sin   (cord_sin),
        .o_done  (cord_done)
    );

    api_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_t),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    api_mul #(
        .POS_BITS (POS_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_p     (mul_p),
        .i_q     (mul_q),
        .o_r     (mul_r),
        .o_done  (mul_done)
    );

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = (r_state == ST_OUT);
    assign o_cfg_ready    = (r_state == ST_IDLE);
    assign o_pose_x       = r_cur_x;
    assign o_pose_y       = r_cur_y;
    assign o_pose_heading = r_heading;

endmodule

`default_nettype wire

// File: hdl/api_checker.sv
// Port-level assertions for the arc pose integrator, bound to the top level.
`default_nettype none

module api_checker #(
    parameter int POS_BITS   = 32,
    parameter int ANGLE_BITS = 16
) (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_in_valid,
    input wire logic                    o_in_stall,
    input wire logic                    o_out_valid,
    input wire logic                    i_out_stall,
    input wire logic [POS_BITS-1:0]     o_pose_x,
    input wire logic [POS_BITS-1:0]     o_pose_y,
    input wire logic [ANGLE_BITS-1:0]   o_pose_heading
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            ($stable(o_pose_x) && $stable(o_pose_y) && $stable(o_pose_heading)))
        else $error("stalled result item changed");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while a result item waits");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (o_in_stall && !o_out_valid))
        else $error("accepted item did not start work");

    a_pose_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_stall && !o_out_valid && !$past(o_out_valid) && $past(o_in_stall)) |->
            $stable(o_pose_heading) || $rose(o_out_valid))
        else $error("heading moved during work");

endmodule

bind arc_pose_integrator api_checker #(
    .POS_BITS   (POS_BITS),
    .ANGLE_BITS (ANGLE_BITS)
) u_api_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_pose_x       (o_pose_x),
    .o_pose_y       (o_pose_y),
    .o_pose_heading (o_pose_heading)
);

`default_nettype wire
